@@ src/cl_pkg.sv @@
// Shared types and constants for the compacting list table.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cl_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefElemWidth = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned IndexW       = 4;
  localparam int unsigned CountOutW    = 5;

  typedef enum logic [OpW-1:0] {
    OpAppend    = 3'd0,
    OpGet       = 3'd1,
    OpRemoveVal = 3'd2,
    OpRemoveIdx = 3'd3,
    OpContains  = 3'd4,
    OpClear     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StRange   = 2'd2,
    StMissing = 2'd3
  } status_e;

  // Per-cell command from the control logic.
  typedef struct packed {
    logic shift;  // take the word of the right-hand neighbor
    logic load;   // take the request value
  } cell_ctrl_t;

  // Per-cell flags toward the control logic.
  typedef struct packed {
    logic below;  // slot lies below the element count
    logic tail;   // slot is the first free one
    logic match;  // stored word equals the request value
    logic hit;    // slot position equals the request index
    logic past;   // slot position is at or beyond the request index
  } cell_stat_t;

endpackage

@@ src/compacting_list_table.sv @@
// Top level of the compacting list table: request register, control logic,
// the row of cl_cell slots and the result register. Depends on cl_pkg, cl_cell.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | sink      | in_valid_i/in_ready_o | operation_i, value_i, index_i
//  out     | source    | out_valid_o/out_ready_i | success_o, read_value_o, status_o,
//          |           |                       | count_o, empty_res_o
//
// Every request beat yields exactly one result beat. The cells compare and
// shift while the beat sits in the request register, in the cycle in which it
// executes, and the result register loads at the end of that cycle. The request
// register refills in the same cycle it empties, so a new beat can be taken
// every cycle as long as the result side keeps up; a stalled result holds the
// request register and from there the input. Reset clears the element count
// and both valid flags; the slot words need no reset, since only slots below
// the count are ever read.

module compacting_list_table import cl_pkg::*; #(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned ELEM_WIDTH = DefElemWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OpW-1:0]       operation_i,
  input  logic [ValueW-1:0]    value_i,
  input  logic [IndexW-1:0]    index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 success_o,
  output logic [ValueW-1:0]    read_value_o,
  output logic [1:0]           status_o,
  output logic [CountOutW-1:0] count_o,
  output logic                 empty_res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Request register.
  logic                  req_valid_q, req_valid_d;
  op_e                   req_op_q;
  logic [ELEM_WIDTH-1:0] req_value_q;
  logic [IndexW-1:0]     req_index_q;

  // List state and result register.
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 success_q, success_d;
  logic [ValueW-1:0]    rd_q, rd_d;
  status_e              status_q, status_d;
  logic [CountOutW-1:0] count_q;
  logic                 empty_q;

  logic in_fire;
  logic exec;

  // The request executes once the result register is free or being emptied.
  assign exec       = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || exec;
  assign in_fire    = in_valid_i && in_ready_o;

  // Cell row signals.
  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_rd   [DEPTH];
  cell_stat_t            cell_stat [DEPTH];
  cell_ctrl_t            cell_ctrl [DEPTH];

  logic [DEPTH-1:0] below_v, tail_v, match_v, hit_v, past_v;
  logic [DEPTH-1:0] shift_v, load_v;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] nbr;

    // The last slot has no right-hand neighbor; it keeps its own word, which
    // lies at or beyond the count after any shift.
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    assign cell_ctrl[i].shift = exec && shift_v[i];
    assign cell_ctrl[i].load  = exec && load_v[i];

    cl_cell #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .POS        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .value_i (req_value_q),
      .index_i (req_index_q),
      .count_i (cnt_q),
      .ctrl_i  (cell_ctrl[i]),
      .nbr_i   (nbr),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i]),
      .stat_o  (cell_stat[i])
    );

    assign below_v[i] = cell_stat[i].below;
    assign tail_v[i]  = cell_stat[i].tail;
    assign match_v[i] = cell_stat[i].match && cell_stat[i].below;
    assign hit_v[i]   = cell_stat[i].hit && cell_stat[i].below;
    assign past_v[i]  = cell_stat[i].past;
  end

  // The slots at and after the first live match form a thermometer; a
  // log-depth prefix OR builds it from the match vector.
  logic [DEPTH-1:0] first_on;

  always_comb begin
    first_on = match_v;
    for (int unsigned s = 1; s < DEPTH; s = s * 2) begin
      first_on = first_on | (first_on << s);
    end
  end

  // Word of the slot addressed by the index; each cell gates its own.
  logic [ELEM_WIDTH-1:0] rd_or;

  always_comb begin
    rd_or = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  logic found;
  logic idx_ok;

  assign found  = |match_v;
  assign idx_ok = |hit_v;

  // Operation decode: count update, cell commands and result fields.
  always_comb begin
    cnt_d     = cnt_q;
    shift_v   = '0;
    load_v    = '0;
    success_d = 1'b0;
    rd_d      = '0;
    status_d  = StOk;
    unique case (req_op_q)
      OpAppend: begin
        if (cnt_q < CntW'(DEPTH)) begin
          load_v    = tail_v;
          cnt_d     = CntW'(cnt_q + 1'b1);
          success_d = 1'b1;
        end else begin
          status_d = StFull;
        end
      end
      OpGet: begin
        if (idx_ok) begin
          rd_d      = ValueW'(rd_or);
          success_d = 1'b1;
        end else begin
          status_d = StRange;
        end
      end
      OpRemoveVal: begin
        if (found) begin
          shift_v   = first_on & below_v;
          cnt_d     = CntW'(cnt_q - 1'b1);
          success_d = 1'b1;
        end else begin
          status_d = StMissing;
        end
      end
      OpRemoveIdx: begin
        if (idx_ok) begin
          shift_v   = past_v & below_v;
          cnt_d     = CntW'(cnt_q - 1'b1);
          success_d = 1'b1;
        end else begin
          status_d = StRange;
        end
      end
      OpContains: begin
        if (found) begin
          success_d = 1'b1;
        end else begin
          status_d = StMissing;
        end
      end
      OpClear: begin
        cnt_d     = '0;
        success_d = 1'b1;
      end
      default: begin
        // Unused operation codes leave the list alone and report neither success nor a failure code.
      end
    endcase
  end

  always_comb begin
    req_valid_d = req_valid_q;
    if (exec) begin
      req_valid_d = 1'b0;
    end
    if (in_fire) begin
      req_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_op_q    <= op_e'(operation_i);
      req_value_q <= ELEM_WIDTH'(value_i);
      req_index_q <= index_i;
    end
    if (exec) begin
      success_q <= success_d;
      rd_q      <= rd_d;
      status_q  <= status_d;
      count_q   <= CountOutW'(cnt_d);
      empty_q   <= cnt_d == '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign success_o    = success_q;
  assign read_value_o = rd_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign empty_res_o  = empty_q;

endmodule

@@ src/cl_cell.sv @@
// One slot of the list: holds a word, compares it and shifts it left.
// Depends on cl_pkg for the control and flag structs.
`timescale 1ns / 1ps

module cl_cell import cl_pkg::*; #(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned ELEM_WIDTH = DefElemWidth,
  parameter int unsigned POS        = 0
) (
  input  logic                            clk_i,
  input  logic [ELEM_WIDTH-1:0]           value_i,
  input  logic [IndexW-1:0]               index_i,
  input  logic [$clog2(DEPTH+1)-1:0]      count_i,
  input  cell_ctrl_t                      ctrl_i,
  input  logic [ELEM_WIDTH-1:0]           nbr_i,
  output logic [ELEM_WIDTH-1:0]           data_o,
  output logic [ELEM_WIDTH-1:0]           rd_o,
  output cell_stat_t                      stat_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SlotW = ($clog2(DEPTH) > IndexW) ? $clog2(DEPTH) : IndexW;

  logic [ELEM_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = nbr_i;
    end else if (ctrl_i.load) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stat_o.below = CntW'(POS) < count_i;
  assign stat_o.tail  = CntW'(POS) == count_i;
  assign stat_o.match = data_q == value_i;
  assign stat_o.hit   = SlotW'(index_i) == SlotW'(POS);
  assign stat_o.past  = SlotW'(POS) >= SlotW'(index_i);

  assign data_o = data_q;
  assign rd_o   = stat_o.hit ? data_q : '0;

endmodule

@@ src/cl_checker.sv @@
// Port-level checks for compacting_list_table and the bind that attaches them.
// Depends on cl_pkg and on the top level's port list.
`timescale 1ns / 1ps

module cl_checker import cl_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 success_o,
  input logic [ValueW-1:0]    read_value_o,
  input logic [1:0]           status_o,
  input logic [CountOutW-1:0] count_o,
  input logic                 empty_res_o
);

  // A stalled result beat holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(status_o) && $stable(count_o) && $stable(success_o))
    else $error("result beat changed while stalled");

  // The reported count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 31) || (32'(count_o) <= DEPTH))
    else $error("count beyond capacity");

  // The empty flag agrees with the count.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (DEPTH <= 31) |-> empty_res_o == (count_o == '0))
    else $error("empty flag disagrees with count");

  // A failure code never comes with success.
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> !success_o)
    else $error("failure status with success set");

  // Read data is zero unless a read succeeded.
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_value_o != '0) |-> success_o && (status_o == StOk))
    else $error("read data without a successful get");

endmodule

bind compacting_list_table cl_checker #(
  .DEPTH (DEPTH)
) u_cl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .success_o    (success_o),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .count_o      (count_o),
  .empty_res_o  (empty_res_o)
);
